// ===== hdl/tdpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tdpf_pkg;

  // Default operand width of the factorizer.
  localparam int WIDTH_DEF = 40;

  // Most results kept for one request; later factors are dropped.
  localparam int MAX_RESULTS = 11;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Commands from the sequencer to the result stage.
  typedef struct packed {
    logic push;   // take a new factor into the pending slot
    logic flush;  // send the pending factor out as the final one
  } oq_cmd_t;

  // Status of the result stage back to the sequencer.
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } oq_stat_t;

endpackage
`default_nettype wire

// ===== hdl/trial_division_prime_factorizer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Trial-division prime factorizer.
// Input channel s_*: one request per number; s_tdata carries value in its low WIDTH bits.
// Output channel m_*: one result per distinct prime factor, ascending; m_tdata carries
// the factor, m_tlast marks the final result of a request. Inputs 0 and 1 give a
// single result with factor 0.
// One request is worked on at a time; s_tready is high only while the unit is idle.
// Every trial divisor costs one pass of the bit-serial divider.
// The divider gives quotient and remainder together, so one pass decides both
// divisibility and the square-root stop. A request takes one pass per trial and
// per repeated division, the most for a large prime input.
// The last found factor waits in a pending slot so that m_tlast can be set on it;
// results leave through a separate output register.
// When the receiver stalls, the sequencer holds at its next emit and waits.
// Reset empties the output register and returns the sequencer to idle.
module trial_division_prime_factorizer_unit import tdpf_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [((WIDTH + 7) / 8) * 8 - 1:0] s_tdata,   // value
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [((WIDTH + 7) / 8) * 8 - 1:0]     m_tdata,   // factor
  output logic                                   m_tlast
);

  localparam int TDATA_W = ((WIDTH + 7) / 8) * 8;
  // divisors never pass sqrt(2^WIDTH) + 2
  localparam int DW = (WIDTH + 1) / 2 + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_PUSH  = 5'b00100,
    S_FINAL = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [WIDTH-1:0] rem, rem_next;
  logic [DW-1:0]    dvs, dvs_next;
  logic             found, found_next;
  logic [CNT_W-1:0] count, count_next;

  logic             div_start;
  logic             div_done;
  logic [WIDTH-1:0] div_quo;
  logic [DW-1:0]    div_rem;

  oq_cmd_t          oq_cmd;
  oq_stat_t         oq_stat;
  logic [WIDTH-1:0] push_val;
  logic [WIDTH-1:0] out_factor;

  logic [WIDTH-1:0] value;
  logic             full;
  logic             fits;   // divisor <= quotient, i.e. divisor squared <= remaining
  logic             exact;

  assign value    = s_tdata[WIDTH-1:0];
  assign s_tready = (state == S_IDLE);
  assign full     = (count == CNT_W'(MAX_RESULTS));
  assign fits     = (WIDTH'(dvs) <= div_quo);
  assign exact    = (div_rem == '0);
  assign m_tdata  = TDATA_W'(out_factor);

  always_comb begin
    state_next = state;
    rem_next   = rem;
    dvs_next   = dvs;
    found_next = found;
    count_next = count;
    div_start  = 1'b0;
    oq_cmd     = '0;
    push_val   = rem;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          dvs_next   = DW'(2);
          found_next = 1'b0;
          count_next = '0;
          if (value <= WIDTH'(1)) begin
            // no prime factors: report a single zero
            rem_next   = '0;
            state_next = S_FINAL;
          end else begin
            rem_next   = value;
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (exact && (found || fits)) begin
            // divide the factor out; report it the first time only
            rem_next   = div_quo;
            found_next = 1'b1;
            if (found) begin
              div_start = 1'b1;
            end else begin
              state_next = S_PUSH;
            end
          end else begin
            found_next = 1'b0;
            if (fits) begin
              dvs_next   = (dvs == DW'(2)) ? DW'(3) : dvs + DW'(2);
              div_start  = 1'b1;
            end else if (rem > WIDTH'(1)) begin
              state_next = S_FINAL;
            end else begin
              state_next = S_FLUSH;
            end
          end
        end
      end
      S_PUSH: begin
        push_val = WIDTH'(dvs);
        if (full) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else if (oq_stat.push_ok) begin
          oq_cmd.push = 1'b1;
          count_next  = count + CNT_W'(1);
          div_start   = 1'b1;
          state_next  = S_DIV;
        end
      end
      S_FINAL: begin
        if (full) begin
          state_next = S_FLUSH;
        end else if (oq_stat.push_ok) begin
          oq_cmd.push = 1'b1;
          count_next  = count + CNT_W'(1);
          state_next  = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (oq_stat.flush_ok) begin
          oq_cmd.flush = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rem   <= '0;
      dvs   <= DW'(2);
      found <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      rem   <= rem_next;
      dvs   <= dvs_next;
      found <= found_next;
      count <= count_next;
    end
  end

  tdpf_div #(
    .WIDTH (WIDTH),
    .DW    (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rem_next),
    .divisor   (dvs_next),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  tdpf_outq #(
    .WIDTH (WIDTH)
  ) u_outq (
    .clk        (clk),
    .rst        (rst),
    .cmd        (oq_cmd),
    .factor_in  (push_val),
    .stat       (oq_stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_factor (out_factor),
    .out_last   (m_tlast)
  );

endmodule
`default_nettype wire

// ===== hdl/tdpf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module tdpf_div import tdpf_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF,
  parameter int DW    = (WIDTH + 1) / 2 + 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [DW-1:0]    divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient,
  output logic [DW-1:0]         remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dsr;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;

  assign trial = {remainder, quotient[WIDTH-1]};
  assign diff  = trial - {1'b0, dsr};
  assign take  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      // shift the next dividend bit in, keep the difference when it fits
      remainder <= take ? diff[DW-1:0] : trial[DW-1:0];
      quotient  <= {quotient[WIDTH-2:0], take};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tdpf_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result stage: one pending factor plus the output register.
module tdpf_outq import tdpf_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire oq_cmd_t          cmd,
  input  wire logic [WIDTH-1:0] factor_in,
  output oq_stat_t              stat,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_factor,
  output logic                  out_last
);

  logic             pend_valid;
  logic [WIDTH-1:0] pend;
  logic             out_free;
  logic             do_push;
  logic             do_flush;

  assign out_free      = !out_valid || out_ready;
  assign stat.push_ok  = !pend_valid || out_free;
  assign stat.flush_ok = out_free;
  assign do_push       = cmd.push && stat.push_ok;
  assign do_flush      = cmd.flush && stat.flush_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_push) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
        pend_valid <= 1'b1;
      end
      if (do_flush) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      if (pend_valid) begin
        out_factor <= pend;
        out_last   <= 1'b0;
      end
      pend <= factor_in;
    end
    if (do_flush) begin
      out_factor <= pend;
      out_last   <= 1'b1;
    end
  end

endmodule
`default_nettype wire
